// File: hw/rtl/free_block_fit_selector_macros.svh
// Assertion macros for the free block fit selector.
// Taken in by the RTL files that carry concurrent checks; needs nothing else.
`ifndef FREE_BLOCK_FIT_SELECTOR_MACROS_SVH
`define FREE_BLOCK_FIT_SELECTOR_MACROS_SVH

// same-cycle implication
`define FBFS_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define FBFS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: hw/rtl/fbfs_pkg.sv
// Shared types and codes for the free block fit selector.
// No dependencies; used by fbfs_store, fbfs_ctrl and the top level.
package fbfs_pkg;

   typedef enum logic [1:0] {
      FIT_FIRST = 2'd0,
      FIT_NEXT  = 2'd1,
      FIT_BEST  = 2'd2,
      FIT_WORST = 2'd3
   } fit_mode_type;

   localparam logic FUNC_SEARCH = 1'b0;
   localparam logic FUNC_WRITE  = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } fsm_state_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

// File: hw/rtl/fbfs_store.sv
// Slot table memory: one entry per class and slot holding a valid mark and a size.
// One write port, one read port with registered data. Uses fbfs_pkg.
module fbfs_store #(
   parameter int DEPTH     = 192,
   parameter int SIZE_BITS = 32
) (
   input  logic                          clock,
   input  fbfs_pkg::mem_ctl_type         mem_ctl,
   input  logic [$clog2(DEPTH)-1:0]      mem_addr,
   input  logic                          wr_valid,
   input  logic [SIZE_BITS-1:0]          wr_size,
   output logic                          rd_valid,
   output logic [SIZE_BITS-1:0]          rd_size
);

   logic [SIZE_BITS:0] mem [DEPTH];
   logic [SIZE_BITS:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem[mem_addr] <= {wr_valid, wr_size};
      end
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   assign rd_valid = rd_data_ff[SIZE_BITS];
   assign rd_size  = rd_data_ff[SIZE_BITS-1:0];

endmodule

// File: hw/rtl/fbfs_ctrl.sv
// Sequencer and fit datapath: clearing pass, slot writes, table scan, rovers, result.
// Drives fbfs_store; uses fbfs_pkg and the assertion macro header.
`include "free_block_fit_selector_macros.svh"

module fbfs_ctrl #(
   parameter int SLOTS     = 64,
   parameter int CLASSES   = 3,
   parameter int SIZE_BITS = 32,
   localparam int TOTAL    = CLASSES * SLOTS,
   localparam int ADDR_W   = $clog2(TOTAL)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  fbfs_pkg::fit_mode_type  fit_mode,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_func,
   input  logic [1:0]              req_list_class,
   input  logic [31:0]             req_request_size,
   input  logic [5:0]              req_slot,
   input  logic [31:0]             req_entry_size,
   input  logic                    req_entry_free,
   output logic                    rsp_valid,
   output logic                    rsp_found,
   output logic [5:0]              rsp_chosen_slot,
   output logic [31:0]             rsp_chosen_size,
   output fbfs_pkg::mem_ctl_type   mem_ctl,
   output logic [ADDR_W-1:0]       mem_addr,
   output logic                    wr_valid,
   output logic [SIZE_BITS-1:0]    wr_size,
   input  logic                    rd_valid,
   input  logic [SIZE_BITS-1:0]    rd_size
);

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CLS_W  = (CLASSES > 1) ? $clog2(CLASSES) : 1;
   localparam int CMP_W  = (SIZE_BITS > 32) ? SIZE_BITS : 32;

   function automatic logic [SLOT_W-1:0] slot_wrap(input logic [SLOT_W-1:0] s);
      return (s == SLOT_W'(SLOTS - 1)) ? '0 : s + 1'b1;
   endfunction

   fbfs_pkg::fsm_state_type state_ff, state_in;

   logic                 accept, is_write, cls_ok, slot_ok, start_scan;
   logic [CLS_W-1:0]     cls_idx;
   logic [ADDR_W-1:0]    req_base;

   logic [CLS_W-1:0]     cls_ff;
   logic [CMP_W-1:0]     req_ff;
   logic [ADDR_W-1:0]    base_ff;
   logic [SLOT_W-1:0]    idx_ff;
   logic [SLOT_W-1:0]    cnt_ff;
   logic [ADDR_W-1:0]    clr_ff;
   logic                 rd_vld_ff;
   logic [SLOT_W-1:0]    rd_slot_ff;
   logic                 hit_ff;
   logic [SLOT_W-1:0]    pick_ff;
   logic [SIZE_BITS-1:0] psize_ff;
   logic [SLOT_W-1:0]    rover_ff [CLASSES];

   logic                 fit, take;
   logic                 cand_hit;
   logic [SLOT_W-1:0]    cand_pick;
   logic [SIZE_BITS-1:0] cand_size;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [5:0]           rsp_slot_ff, rsp_slot_in;
   logic [31:0]          rsp_size_ff, rsp_size_in;

   assign busy       = (state_ff != fbfs_pkg::ST_IDLE);
   assign accept     = start && !busy;
   assign is_write   = (req_func == fbfs_pkg::FUNC_WRITE);
   assign cls_ok     = (32'(req_list_class) < CLASSES);
   assign slot_ok    = (32'(req_slot) < SLOTS);
   assign cls_idx    = CLS_W'(req_list_class);
   assign req_base   = ADDR_W'(32'(cls_idx) * SLOTS);
   assign start_scan = accept && !is_write && cls_ok;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fbfs_pkg::ST_CLEAR: begin
            if (clr_ff == ADDR_W'(TOTAL - 1)) state_in = fbfs_pkg::ST_IDLE;
         end
         fbfs_pkg::ST_IDLE: begin
            if (start_scan) state_in = fbfs_pkg::ST_SCAN;
         end
         fbfs_pkg::ST_SCAN: begin
            if (cnt_ff == SLOT_W'(SLOTS - 1)) state_in = fbfs_pkg::ST_DRAIN;
         end
         fbfs_pkg::ST_DRAIN: begin
            state_in = fbfs_pkg::ST_IDLE;
         end
         default: begin
            state_in = fbfs_pkg::ST_CLEAR;
         end
      endcase
   end

   // memory port
   always_comb begin
      mem_ctl  = '0;
      mem_addr = '0;
      wr_valid = req_entry_free;
      wr_size  = SIZE_BITS'(req_entry_size);
      unique case (state_ff)
         fbfs_pkg::ST_CLEAR: begin
            mem_ctl.wr_en = 1'b1;
            mem_addr      = clr_ff;
            wr_valid      = 1'b0;
            wr_size       = '0;
         end
         fbfs_pkg::ST_IDLE: begin
            mem_ctl.wr_en = accept && is_write && cls_ok && slot_ok;
            mem_addr      = req_base + ADDR_W'(req_slot);
         end
         fbfs_pkg::ST_SCAN: begin
            mem_ctl.rd_en = 1'b1;
            mem_addr      = base_ff + ADDR_W'(idx_ff);
         end
         default: begin
            mem_ctl = '0;
         end
      endcase
   end

   // candidate update
   always_comb begin
      fit = rd_valid && (req_ff <= CMP_W'(rd_size));
      unique case (fit_mode)
         fbfs_pkg::FIT_FIRST,
         fbfs_pkg::FIT_NEXT:  take = fit && !hit_ff;
         fbfs_pkg::FIT_BEST:  take = fit && (!hit_ff || rd_size < psize_ff);
         fbfs_pkg::FIT_WORST: take = fit && (!hit_ff || rd_size > psize_ff);
         default:             take = 1'b0;
      endcase
      take      = take && rd_vld_ff;
      cand_hit  = hit_ff || take;
      cand_pick = take ? rd_slot_ff : pick_ff;
      cand_size = take ? rd_size : psize_ff;
   end

   // result
   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_found_in = 1'b0;
      rsp_slot_in  = '0;
      rsp_size_in  = '0;
      priority if (state_ff == fbfs_pkg::ST_DRAIN) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = cand_hit;
         rsp_slot_in  = cand_hit ? 6'(cand_pick) : '0;
         rsp_size_in  = cand_hit ? 32'(cand_size) : '0;
      end else if (accept && !start_scan) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbfs_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CLASSES; c++) begin
            rover_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= (state_ff == fbfs_pkg::ST_SCAN);
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == fbfs_pkg::ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (state_ff == fbfs_pkg::ST_DRAIN && cand_hit &&
             fit_mode == fbfs_pkg::FIT_NEXT) begin
            rover_ff[cls_ff] <= slot_wrap(cand_pick);
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_size_ff  <= rsp_size_in;
      rd_slot_ff   <= idx_ff;
      if (start_scan) begin
         cls_ff  <= cls_idx;
         req_ff  <= CMP_W'(req_request_size);
         base_ff <= req_base;
         idx_ff  <= (fit_mode == fbfs_pkg::FIT_NEXT) ? rover_ff[cls_idx] : '0;
         cnt_ff  <= '0;
         hit_ff  <= 1'b0;
      end else begin
         if (state_ff == fbfs_pkg::ST_SCAN) begin
            idx_ff <= slot_wrap(idx_ff);
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (rd_vld_ff) begin
            hit_ff   <= cand_hit;
            pick_ff  <= cand_pick;
            psize_ff <= cand_size;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_chosen_slot = rsp_slot_ff;
   assign rsp_chosen_size = rsp_size_ff;

   `FBFS_ASSERT_IMPLY(a_no_rsp_in_clear, clock, reset, state_ff == fbfs_pkg::ST_CLEAR, !rsp_valid_ff)
   `FBFS_ASSERT_NEXT(a_write_rsp, clock, reset, accept && is_write, rsp_valid_ff && !rsp_found_ff)
   `FBFS_ASSERT_NEXT(a_scan_start, clock, reset, start_scan, state_ff == fbfs_pkg::ST_SCAN)
   `FBFS_ASSERT_IMPLY(a_hit_fits, clock, reset, rsp_valid_ff && rsp_found_ff, req_ff <= CMP_W'(psize_ff))

endmodule

// File: hw/rtl/free_block_fit_selector.sv
// Free block fit selector: after reset a clearing pass marks every slot empty, with
// busy high. A slot write, or a search on a class out of range, is taken while idle
// and strobes its result on the next. A search reads the class's table one slot per
// cycle from the slot memory, then in the drain state the result is registered; busy
// stays high through the scan and the drain. Results are shown for one cycle only.
// Top level; instantiates fbfs_ctrl and fbfs_store, uses fbfs_pkg.
module free_block_fit_selector #(
   parameter int SLOTS     = 64,
   parameter int CLASSES   = 3,
   parameter int SIZE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_func,
   input  logic [1:0]  req_list_class,
   input  logic [31:0] req_request_size,
   input  logic [5:0]  req_slot,
   input  logic [31:0] req_entry_size,
   input  logic        req_entry_free,
   output logic        rsp_valid,
   output logic        rsp_found,
   output logic [5:0]  rsp_chosen_slot,
   output logic [31:0] rsp_chosen_size,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_fit_mode
);

   localparam int TOTAL  = CLASSES * SLOTS;
   localparam int ADDR_W = $clog2(TOTAL);

   fbfs_pkg::fit_mode_type fit_mode_ff;
   fbfs_pkg::mem_ctl_type  mem_ctl;
   logic [ADDR_W-1:0]      mem_addr;
   logic                   wr_valid;
   logic [SIZE_BITS-1:0]   wr_size;
   logic                   rd_valid;
   logic [SIZE_BITS-1:0]   rd_size;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff <= fbfs_pkg::FIT_FIRST;
      end else if (csr_valid && csr_ready) begin
         fit_mode_ff <= fbfs_pkg::fit_mode_type'(csr_fit_mode);
      end
   end

   fbfs_ctrl #(
      .SLOTS     (SLOTS),
      .CLASSES   (CLASSES),
      .SIZE_BITS (SIZE_BITS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .fit_mode         (fit_mode_ff),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_list_class   (req_list_class),
      .req_request_size (req_request_size),
      .req_slot         (req_slot),
      .req_entry_size   (req_entry_size),
      .req_entry_free   (req_entry_free),
      .rsp_valid        (rsp_valid),
      .rsp_found        (rsp_found),
      .rsp_chosen_slot  (rsp_chosen_slot),
      .rsp_chosen_size  (rsp_chosen_size),
      .mem_ctl          (mem_ctl),
      .mem_addr         (mem_addr),
      .wr_valid         (wr_valid),
      .wr_size          (wr_size),
      .rd_valid         (rd_valid),
      .rd_size          (rd_size)
   );

   fbfs_store #(
      .DEPTH     (TOTAL),
      .SIZE_BITS (SIZE_BITS)
   ) u_store (
      .clock    (clock),
      .mem_ctl  (mem_ctl),
      .mem_addr (mem_addr),
      .wr_valid (wr_valid),
      .wr_size  (wr_size),
      .rd_valid (rd_valid),
      .rd_size  (rd_size)
   );

endmodule
